>>> rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// Stream pattern replace package
// Shared constants, register indexes and the job record that travels from
// the classifying front end to the output sequencer.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Widest pattern the job record can carry, in bytes.
  localparam int JOB_BYTES   = 8;
  localparam int JOB_IDX_W   = $clog2(JOB_BYTES);
  // Width of the length registers and of every byte count.
  localparam int LEN_W       = 4;
  localparam int PAT_W       = 64;
  localparam int REG_IDX_W   = 2;

  localparam int SEARCH_MAX_DEF  = 8;
  localparam int REPLACE_MAX_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEARCH_PATTERN  = 2'd0,
    REG_SEARCH_LENGTH   = 2'd1,
    REG_REPLACE_PATTERN = 2'd2,
    REG_REPLACE_LENGTH  = 2'd3
  } spr_reg_t;

  // One job is the whole set of results caused by one input item. A count of
  // zero with last set stands for the lone end marker.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          count;
    logic                      last;
  } spr_job_t;

endpackage

>>> rtl/spr_in_if.sv
// ----------------------------------------------------------------------------
// Stream pattern replace input channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface spr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_last;

  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

>>> rtl/spr_out_if.sv
// ----------------------------------------------------------------------------
// Stream pattern replace result channel
// Valid/ready channel carrying one output byte with its framing flags.
// ----------------------------------------------------------------------------
interface spr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output byte_valid,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input run_last, input text_end, output ready);
endinterface

>>> rtl/stream_pattern_replace.sv
// ----------------------------------------------------------------------------
// Stream pattern replace top level
// Streaming find-and-replace on a byte text with configurable patterns.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and replaces every leftmost,
// non-overlapping occurrence of the search pattern with the replacement,
// resuming the scan after the matched bytes; replacement bytes are never
// rescanned. Results leave at one per cycle while the output is not stalled
// through a registered output stage; an item causes 0 to 8 results. The
// input keeps taking one item per cycle as long as the job queue between
// the two halves has room, so the sustained rate is set by the output
// sequencer, and an item that causes no result uses no output slot. An
// accepted item is written into the job queue and its first result then
// passes through the output register. The user must write the configuration
// registers through the cfg_ port only while the block is idle; the block
// itself does not enforce this. Writing the search length empties the
// pending byte window, so a new length takes effect cleanly between texts.
// ----------------------------------------------------------------------------
module stream_pattern_replace #(
  parameter int SEARCH_MAX  = spr_pkg::SEARCH_MAX_DEF,
  parameter int REPLACE_MAX = spr_pkg::REPLACE_MAX_DEF,
  parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  spr_in_if.sink                        in_if,
  spr_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [spr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [spr_pkg::PAT_W-1:0]     cfg_data
);

  localparam int LEN_W = spr_pkg::LEN_W;
  localparam int PAT_W = spr_pkg::PAT_W;

  // Configuration registers, reset to the documented defaults.
  logic [PAT_W-1:0] search_pattern_r, replace_pattern_r;
  logic [LEN_W-1:0] search_length_r, replace_length_r;
  logic             win_clear;

  // Writing the search length also discards any pending window bytes.
  assign win_clear = cfg_we && (cfg_index == spr_pkg::REG_SEARCH_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_pattern_r  <= '0;
      search_length_r   <= LEN_W'(1);
      replace_pattern_r <= '0;
      replace_length_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spr_pkg::REG_SEARCH_PATTERN:  search_pattern_r  <= cfg_data;
        spr_pkg::REG_SEARCH_LENGTH:   search_length_r   <= cfg_data[LEN_W-1:0];
        spr_pkg::REG_REPLACE_PATTERN: replace_pattern_r <= cfg_data;
        spr_pkg::REG_REPLACE_LENGTH:  replace_length_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: window, compare and job building.
  spr_pkg::spr_job_t push_job, head_job;
  logic              job_push, q_full, q_empty, q_pop;

  spr_front #(
    .SEARCH_MAX  (SEARCH_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_if           (in_if),
    .search_pattern  (search_pattern_r),
    .search_length   (search_length_r),
    .replace_pattern (replace_pattern_r),
    .replace_length  (replace_length_r),
    .win_clear       (win_clear),
    .q_full          (q_full),
    .job_push        (job_push),
    .job             (push_job)
  );

  // The queue lets the front end run ahead while a long burst drains.
  spr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head_job)
  );

  // Back end: one result per cycle into the output register while the output is not stalled.
  spr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

>>> rtl/spr_front.sv
// ----------------------------------------------------------------------------
// Stream pattern replace front end
// Accepts input items, keeps the pending byte window, compares it against
// the search pattern and turns each item into at most one job for the back end.
// ----------------------------------------------------------------------------
module spr_front #(
  parameter int SEARCH_MAX  = spr_pkg::SEARCH_MAX_DEF,
  parameter int REPLACE_MAX = spr_pkg::REPLACE_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  spr_in_if.sink                     in_if,
  input  logic [spr_pkg::PAT_W-1:0]  search_pattern,
  input  logic [spr_pkg::LEN_W-1:0]  search_length,
  input  logic [spr_pkg::PAT_W-1:0]  replace_pattern,
  input  logic [spr_pkg::LEN_W-1:0]  replace_length,
  input  logic                       win_clear,
  input  logic                       q_full,
  output logic                       job_push,
  output spr_pkg::spr_job_t          job
);

  localparam int LEN_W = spr_pkg::LEN_W;

  logic [7:0]       win_r   [SEARCH_MAX];
  logic [7:0]       win_new [SEARCH_MAX];
  logic [7:0]       win_nxt [SEARCH_MAX];
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] slen, rlen, eff_fill, fill_inc;
  logic             accept, full, match;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;

  // Out-of-range lengths are clamped to the legal span.
  always_comb begin
    slen = search_length;
    if (slen == '0) begin
      slen = LEN_W'(1);
    end else if (slen > LEN_W'(SEARCH_MAX)) begin
      slen = LEN_W'(SEARCH_MAX);
    end
    rlen = replace_length;
    if (rlen > LEN_W'(REPLACE_MAX)) begin
      rlen = LEN_W'(REPLACE_MAX);
    end
  end

  // Place the new byte, then compare the first slen window bytes.
  always_comb begin
    eff_fill = (fill_r >= slen) ? '0 : fill_r;
    fill_inc = eff_fill + LEN_W'(1);
    full     = (fill_inc == slen);
    match    = 1'b1;
    for (int i = 0; i < SEARCH_MAX; i++) begin
      win_new[i] = (LEN_W'(i) == eff_fill) ? in_if.data_byte : win_r[i];
      if (LEN_W'(i) < slen && win_new[i] != search_pattern[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  // Job contents and the window update.
  always_comb begin
    job       = '0;
    job.last  = in_if.stream_last;
    for (int i = 0; i < SEARCH_MAX - 1; i++) begin
      win_nxt[i] = (full && !match) ? win_new[i+1] : win_new[i];
    end
    win_nxt[SEARCH_MAX-1] = win_new[SEARCH_MAX-1];

    if (full && match) begin
      for (int j = 0; j < spr_pkg::JOB_BYTES; j++) begin
        job.bytes[j] = replace_pattern[8*j +: 8];
      end
      job.count = rlen;
    end else begin
      for (int j = 0; j < SEARCH_MAX; j++) begin
        job.bytes[j] = win_new[j];
      end
      if (full) begin
        job.count = in_if.stream_last ? slen : LEN_W'(1);
      end else begin
        job.count = in_if.stream_last ? fill_inc : '0;
      end
    end

    if (in_if.stream_last || (full && match)) begin
      fill_nxt = '0;
    end else if (full) begin
      fill_nxt = slen - LEN_W'(1);
    end else begin
      fill_nxt = fill_inc;
    end
  end

  assign job_push = accept && (job.count != '0 || in_if.stream_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (win_clear) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < SEARCH_MAX; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

>>> rtl/spr_queue.sv
// ----------------------------------------------------------------------------
// Stream pattern replace job queue
// Small first-in first-out buffer of jobs between front end and back end.
// ----------------------------------------------------------------------------
module spr_queue #(
  parameter int DEPTH = spr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spr_pkg::spr_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output spr_pkg::spr_job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spr_pkg::spr_job_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/spr_back.sv
// ----------------------------------------------------------------------------
// Stream pattern replace back end
// Walks the job at the head of the queue one result per cycle, while the output
// is not stalled, into the registered output stage.
// ----------------------------------------------------------------------------
module spr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  spr_pkg::spr_job_t head,
  input  logic              q_empty,
  output logic              q_pop,
  spr_out_if.source         out_if
);

  localparam int IDX_W = spr_pkg::JOB_IDX_W;
  localparam int LEN_W = spr_pkg::LEN_W;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             bvalid_r, run_last_r, text_end_r;
  logic             load, emit, fin;
  logic [LEN_W-1:0] n_res;

  assign load  = !valid_r || out_if.ready;
  assign emit  = !q_empty && load;
  assign n_res = (head.count == '0) ? LEN_W'(1) : head.count;
  assign fin   = (idx_r == IDX_W'(n_res - LEN_W'(1)));
  assign q_pop = emit && fin;

  always_comb begin
    idx_nxt = idx_r;
    if (q_pop) begin
      idx_nxt = '0;
    end else if (emit) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    valid_nxt = emit ? 1'b1 : (out_if.ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r     <= (head.count == '0) ? 8'd0 : head.bytes[idx_r];
      bvalid_r   <= (head.count != '0);
      run_last_r <= fin;
      text_end_r <= fin && head.last;
    end
  end

  assign out_if.valid      = valid_r;
  assign out_if.out_byte   = byte_r;
  assign out_if.byte_valid = bvalid_r;
  assign out_if.run_last   = run_last_r;
  assign out_if.text_end   = text_end_r;

endmodule

>>> rtl/spr_checker.sv
// ----------------------------------------------------------------------------
// Stream pattern replace port checker
// Watches the top-level ports for framing and reset behavior.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       run_last,
  input logic       text_end
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(byte_valid) && $stable(run_last) && $stable(text_end))
    else $error("result changed while stalled");

  // The end of a text always closes the run of its item.
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && text_end |-> run_last)
    else $error("text_end without run_last");

  // An end marker without a byte only appears as the final result of a text.
  a_marker_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> run_last && text_end && out_byte == 8'd0)
    else $error("end marker is not the final result");

  // Reset empties the output and the queue.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_byte   (out_if.out_byte),
  .byte_valid (out_if.byte_valid),
  .run_last   (out_if.run_last),
  .text_end   (out_if.text_end)
);
